// ===== rtl/salct_pkg.sv =====
// salct_pkg: shared constants and types for the cache tag store
// no dependencies
package salct_pkg;

    localparam int DEF_MAX_SETS = 256;
    localparam int DEF_MAX_WAYS = 8;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int CNT_W      = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        OC_HIT   = 2'd0,
        OC_FILL  = 2'd1,
        OC_EVICT = 2'd2
    } t_outcome;

endpackage

// ===== rtl/salct_row_store.sv =====
// salct_row_store: one row per set holding tags, valid bits and recency ranks
// single write port, single registered read port, per-row reset-cleared marks
// depends on nothing
module salct_row_store #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8,
    parameter int WIDTH = 544
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_ok;
    logic [WIDTH-1:0] r_rd;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // a row never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_ok[i_waddr] <= 1'b1;
            end
            r_rd_ok <= r_row_ok[i_raddr];
        end
    end

    assign o_rdata = r_rd_ok ? r_rd : '0;

endmodule

// ===== rtl/salct_lookup.sv =====
// salct_lookup: tag match, free way and lru victim choice, rank update for one set
// depends on salct_pkg
module salct_lookup
    import salct_pkg::*;
#(
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    parameter int WAY_W    = 3
) (
    input  logic [MAX_WAYS-1:0]            i_in_use,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0] i_tags,
    input  logic [MAX_WAYS-1:0]            i_valid,
    input  logic [MAX_WAYS-1:0][WAY_W-1:0] i_ranks,
    output t_outcome                       o_outcome,
    output logic [MAX_WAYS-1:0][TAG_W-1:0] o_tags,
    output logic [MAX_WAYS-1:0]            o_valid,
    output logic [MAX_WAYS-1:0][WAY_W-1:0] o_ranks
);

    localparam logic [WAY_W-1:0] FILL_THR = WAY_W'(MAX_WAYS - 1);

    logic             hit;
    logic             any_free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] vict_way;
    logic [WAY_W-1:0] vict_rank;
    logic [WAY_W-1:0] sel;
    logic [WAY_W-1:0] thr;

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        any_free  = 1'b0;
        free_way  = '0;
        vict_way  = '0;
        vict_rank = i_ranks[0];

        // lowest matching way wins
        for (int v = MAX_WAYS - 1; v >= 0; v--) begin
            if (i_in_use[v] && i_valid[v] && (i_tags[v] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(v);
            end
        end

        // highest invalid way is filled first
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (i_in_use[v] && !i_valid[v]) begin
                any_free = 1'b1;
                free_way = WAY_W'(v);
            end
        end

        // oldest rank, lowest way on a tie
        for (int v = 1; v < MAX_WAYS; v++) begin
            if (i_in_use[v] && (i_ranks[v] > vict_rank)) begin
                vict_way  = WAY_W'(v);
                vict_rank = i_ranks[v];
            end
        end

        if (hit) begin
            sel       = hit_way;
            thr       = i_ranks[hit_way];
            o_outcome = OC_HIT;
        end else if (any_free) begin
            sel       = free_way;
            thr       = FILL_THR;
            o_outcome = OC_FILL;
        end else begin
            sel       = vict_way;
            thr       = vict_rank;
            o_outcome = OC_EVICT;
        end

        o_tags  = i_tags;
        o_valid = i_valid;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (WAY_W'(v) == sel) begin
                o_ranks[v] = '0;
            end else if (i_in_use[v] && (i_ranks[v] < thr)) begin
                o_ranks[v] = i_ranks[v] + 1'b1;
            end else begin
                o_ranks[v] = i_ranks[v];
            end
        end
        if (!hit) begin
            o_tags[sel]  = i_tag;
            o_valid[sel] = 1'b1;
        end
    end

endmodule

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// set_assoc_lru_cache_tags: top level of the set-associative lru tag store
// depends on salct_pkg, salct_row_store, salct_lookup
//
// An access is accepted when start is high and busy is low. The address is split
// in the cycle after the transfer while its set row is read; the lookup stage then
// compares tags and writes the row back, and the result strobe o_valid is registered
// from it. Loads and stores can be given one per cycle while busy is low. A modify
// makes two results in consecutive cycles and holds busy high for one cycle if
// another access is already waiting. The single row read and write port of the set
// store sets this rate; a row just written is forwarded to a following access of
// the same set. Valid bits are cleared at reset with no clearing pass. Results
// cannot be stalled, and the counters on o_hit_total, o_miss_total and
// o_evict_total are only meaningful while o_valid is high. The user must write
// configuration only while no access is in flight; the block does not enforce it.
module set_assoc_lru_cache_tags
    import salct_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [MODE_W-1:0]     i_mode,
    output logic                  o_valid,
    output logic [1:0]            o_outcome,
    output logic                  o_last,
    output logic [CNT_W-1:0]      o_hit_total,
    output logic [CNT_W-1:0]      o_miss_total,
    output logic [CNT_W-1:0]      o_evict_total
);

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W     = MAX_WAYS * (TAG_W + 1 + WAY_W);
    localparam int SBITS_MAX = $clog2(MAX_SETS + 1) - 1;

    // configuration
    logic [3:0] r_set_bits;
    logic [3:0] r_ways_used;
    logic [5:0] r_block_bits;

    // address split stage
    logic              r_a_valid;
    logic [ADDR_W-1:0] r_a_addr;
    logic [MODE_W-1:0] r_a_mode;

    // lookup stage
    logic             r_b_valid;
    logic             r_b_modify;
    logic             r_b_second;
    logic [SET_W-1:0] r_b_set;
    logic [TAG_W-1:0] r_b_tag;

    // forwarding of the last written row
    logic             r_byp_valid;
    logic [SET_W-1:0] r_byp_set;
    logic [ROW_W-1:0] r_byp_row;

    // result
    logic              r_valid;
    t_outcome          r_outcome;
    logic              r_last;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;
    logic [CNT_W-1:0]  r_evicts;

    logic [3:0]        sbits_eff;
    logic [SET_W-1:0]  set_mask;
    logic [ADDR_W-1:0] a_blk;
    logic [SET_W-1:0]  a_set;
    logic [6:0]        a_shift;
    logic [TAG_W-1:0]  a_tag;

    logic b_stall;
    logic accept;
    logic a_adv;

    logic [MAX_WAYS-1:0]            in_use;
    logic [ROW_W-1:0]               rd_row;
    logic [ROW_W-1:0]               b_row;
    logic [ROW_W-1:0]               new_row;
    logic [MAX_WAYS-1:0][TAG_W-1:0] b_tags;
    logic [MAX_WAYS-1:0]            b_valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0] b_ranks;
    logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;
    logic [MAX_WAYS-1:0]            new_valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0] new_ranks;
    t_outcome                       b_outcome;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 4'd0;
            r_ways_used  <= 4'd1;
            r_block_bits <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_wdata[3:0];
                CFG_WAYS_USED:  r_ways_used  <= i_cfg_wdata[3:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ways in use: zero acts as one, large values use all ways
    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_in_use
        assign in_use[g] = (g == 0) || (5'(g) < {1'b0, r_ways_used});
    end

    // address split
    assign sbits_eff = (r_set_bits > 4'(SBITS_MAX)) ? 4'(SBITS_MAX) : r_set_bits;
    assign set_mask  = ~({SET_W{1'b1}} << sbits_eff);
    assign a_blk     = r_a_addr >> r_block_bits;
    assign a_set     = a_blk[SET_W-1:0] & set_mask;
    assign a_shift   = {1'b0, r_block_bits} + {3'b000, sbits_eff};
    assign a_tag     = a_shift[6] ? '0 : (r_a_addr >> a_shift[5:0]);

    // handshake
    assign b_stall = r_b_valid && r_b_modify && !r_b_second;
    assign busy    = r_a_valid && b_stall;
    assign accept  = start && !busy;
    assign a_adv   = r_a_valid && !b_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_addr <= i_address;
            r_a_mode <= i_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_b_second <= 1'b0;
            r_b_modify <= 1'b0;
        end else if (b_stall) begin
            r_b_second <= 1'b1;
        end else if (a_adv) begin
            r_b_valid  <= 1'b1;
            r_b_second <= 1'b0;
            r_b_modify <= (r_a_mode == MODE_MODIFY);
        end else begin
            r_b_valid  <= 1'b0;
            r_b_second <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && !b_stall) begin
            r_b_set <= a_set;
            r_b_tag <= a_tag;
        end
    end

    salct_row_store #(
        .DEPTH (MAX_SETS),
        .IDX_W (SET_W),
        .WIDTH (ROW_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_b_valid),
        .i_waddr (r_b_set),
        .i_wdata (new_row),
        .i_raddr (a_set),
        .o_rdata (rd_row)
    );

    // forward a row written at the last edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else begin
            r_byp_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_byp_set <= r_b_set;
            r_byp_row <= new_row;
        end
    end

    assign b_row = (r_byp_valid && (r_byp_set == r_b_set)) ? r_byp_row : rd_row;
    assign {b_tags, b_valid, b_ranks} = b_row;
    assign new_row = {new_tags, new_valid, new_ranks};

    salct_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W)
    ) u_lookup (
        .i_in_use  (in_use),
        .i_tag     (r_b_tag),
        .i_tags    (b_tags),
        .i_valid   (b_valid),
        .i_ranks   (b_ranks),
        .o_outcome (b_outcome),
        .o_tags    (new_tags),
        .o_valid   (new_valid),
        .o_ranks   (new_ranks)
    );

    // result and running counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else begin
            r_valid <= r_b_valid;
            if (r_b_valid) begin
                case (b_outcome)
                    OC_HIT: begin
                        r_hits <= r_hits + 1'b1;
                    end
                    OC_FILL: begin
                        r_misses <= r_misses + 1'b1;
                    end
                    default: begin
                        r_misses <= r_misses + 1'b1;
                        r_evicts <= r_evicts + 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_outcome <= b_outcome;
            r_last    <= !b_stall;
        end
    end

    assign o_valid       = r_valid;
    assign o_outcome     = r_outcome;
    assign o_last        = r_last;
    assign o_hit_total   = r_hits;
    assign o_miss_total  = r_misses;
    assign o_evict_total = r_evicts;

endmodule
